FILE: rtl/core/midi_clock_tempo_tracker_defines.svh
// Assertion macros for the MIDI clock tempo tracker.
// Used by mctt_back in rtl/core; the macros expect clk and rst_n in scope.
`ifndef MIDI_CLOCK_TEMPO_TRACKER_DEFINES_SVH
`define MIDI_CLOCK_TEMPO_TRACKER_DEFINES_SVH

`ifndef SYNTH
// pre holds in a cycle -> post holds in the same cycle
`define MCTT_ASSERT_IMPL(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("mctt assertion failed");
// pre holds in a cycle -> post holds in the next cycle
`define MCTT_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("mctt assertion failed");
`else
`define MCTT_ASSERT_IMPL(lbl, pre, post)
`define MCTT_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

FILE: rtl/core/mctt_pkg.sv
// Shared types and constants for the MIDI clock tempo tracker.
// No dependencies.
package mctt_pkg;

  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned TS_W    = 32;
  localparam int unsigned TEMPO_W = 16;
  localparam int unsigned COUNT_W = 8;

  // event kinds; the fourth code is ignored
  typedef enum logic [FUNC_W-1:0] {
    FUNC_CLOCK = 2'd0,
    FUNC_START = 2'd1,
    FUNC_STOP  = 2'd2
  } func_t;

  localparam int unsigned PULSES_PER_QUARTER = 24;
  localparam int unsigned MS_PER_MINUTE      = 60000;
  localparam int unsigned PULSE_SCALE        = 4;

  localparam logic [TEMPO_W-1:0] TEMPO_MAX = '1;
  localparam logic [TEMPO_W-1:0] TEMPO_MIN = TEMPO_W'(1);

  // step tick bookkeeping: count restarts at one on a tick
  localparam logic [COUNT_W-1:0] STEP_FIRST = COUNT_W'(1);
  localparam logic [COUNT_W-1:0] STEP_WRAP  = COUNT_W'(4);

  localparam int unsigned QUEUE_DEPTH = 2;

  typedef struct packed {
    logic               is_pulse;
    logic               step_tick;
    logic [COUNT_W-1:0] clock_count;
    logic               is_running;
  } job_ctl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

FILE: rtl/core/mctt_in_if.sv
// Event channel: valid/ready handshake with func and timestamp payload.
// Depends on mctt_pkg.
interface mctt_in_if;
  import mctt_pkg::*;

  logic               valid;
  logic               ready;
  logic [FUNC_W-1:0]  func;
  logic [TS_W-1:0]    timestamp;

  modport source (output valid, func, timestamp, input ready);
  modport sink   (input valid, func, timestamp, output ready);
endinterface

FILE: rtl/core/mctt_out_if.sv
// Result channel: valid/ready handshake with tempo and transport payload.
// Depends on mctt_pkg.
interface mctt_out_if;
  import mctt_pkg::*;

  logic               valid;
  logic               ready;
  logic [TEMPO_W-1:0] tempo_bpm;
  logic               tempo_valid;
  logic               step_tick;
  logic [COUNT_W-1:0] clock_count;
  logic               is_running;

  modport source (output valid, tempo_bpm, tempo_valid, step_tick, clock_count, is_running,
                  input ready);
  modport sink   (input valid, tempo_bpm, tempo_valid, step_tick, clock_count, is_running,
                  output ready);
endinterface

FILE: rtl/core/midi_clock_tempo_tracker.sv
// MIDI clock tempo tracker, top level: front end, two-entry job queue, divider back end.
// Path: an accepted word is pushed into the queue; the back end pops it, runs the
//   bit-serial divider for a clock pulse whose sum is nonzero and at most NUM, and
//   registers the result. The front takes a word every cycle until the queue fills;
//   the back end takes a new job only once the previous result is loaded out.
// Reset (rst_n low, synchronous) clears the ring valid bits, sum, time, count and run flag.
module midi_clock_tempo_tracker #(
  parameter int unsigned WINDOW_DEPTH = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  mctt_in_if.sink    in_ch,
  mctt_out_if.source out_ch
);
  import mctt_pkg::*;

  localparam int unsigned SUM_W  = TS_W + $clog2(WINDOW_DEPTH);
  localparam int unsigned JOB_W  = $bits(job_ctl_t) + SUM_W;

  q_stat_t          q_stat;
  logic             push;
  job_ctl_t         push_ctl;
  logic [SUM_W-1:0] push_sum;
  logic             pop;
  logic [JOB_W-1:0] pop_data;
  job_ctl_t         pop_ctl;
  logic [SUM_W-1:0] pop_sum;

  mctt_front #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .SUM_W        (SUM_W)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .q_stat   (q_stat),
    .push     (push),
    .push_ctl (push_ctl),
    .push_sum (push_sum)
  );

  mctt_queue #(
    .DATA_W (JOB_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({push_ctl, push_sum}),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_stat    (q_stat)
  );

  assign pop_ctl = pop_data[JOB_W-1:SUM_W];
  assign pop_sum = pop_data[SUM_W-1:0];

  mctt_back #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .SUM_W        (SUM_W)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_stat  (q_stat),
    .pop_ctl (pop_ctl),
    .pop_sum (pop_sum),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

FILE: rtl/core/mctt_front.sv
// Front end: takes events, updates gap ring, running sum, count and run flag.
// Depends on mctt_pkg and mctt_in_if; pushes one job per word into the queue.
module mctt_front #(
  parameter int unsigned WINDOW_DEPTH = 8,
  parameter int unsigned SUM_W        = 35
) (
  input  logic               clk,
  input  logic               rst_n,
  mctt_in_if.sink            in_ch,
  input  mctt_pkg::q_stat_t  q_stat,
  output logic               push,
  output mctt_pkg::job_ctl_t push_ctl,
  output logic [SUM_W-1:0]   push_sum
);
  import mctt_pkg::*;

  localparam int unsigned SLOT_W = $clog2(WINDOW_DEPTH);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_DEPTH - 1);

  logic [TS_W-1:0]         last_time_r, last_time_nxt;
  logic [SUM_W-1:0]        sum_r, sum_nxt;
  logic [SLOT_W-1:0]       slot_r, slot_nxt;
  logic [COUNT_W-1:0]      count_r, count_nxt;
  logic                    run_r, run_nxt;
  logic [WINDOW_DEPTH-1:0] valid_r;
  logic [TS_W-1:0]         rd_r;
  logic [TS_W-1:0]         gap_mem [WINDOW_DEPTH];

  logic               accept;
  logic               pulse;
  logic               tick;
  logic [TS_W-1:0]    gap;
  logic [TS_W-1:0]    old_gap;
  logic [SLOT_W-1:0]  slot_inc;
  logic [COUNT_W-1:0] count_inc;

  assign in_ch.ready = !q_stat.full;
  assign accept      = in_ch.valid && in_ch.ready;

  // rd_r always holds the ring entry at slot_r; a never-written entry counts as zero
  assign gap       = in_ch.timestamp - last_time_r;
  assign old_gap   = valid_r[slot_r] ? rd_r : '0;
  assign slot_inc  = (slot_r == SLOT_LAST) ? '0 : slot_r + SLOT_W'(1);
  assign count_inc = count_r + COUNT_W'(1);

  always_comb begin
    last_time_nxt = last_time_r;
    sum_nxt       = sum_r;
    slot_nxt      = slot_r;
    count_nxt     = count_r;
    run_nxt       = run_r;
    pulse         = 1'b0;
    tick          = 1'b0;
    if (accept) begin
      unique case (func_t'(in_ch.func))
        FUNC_CLOCK: begin
          pulse         = 1'b1;
          last_time_nxt = in_ch.timestamp;
          sum_nxt       = sum_r - SUM_W'(old_gap) + SUM_W'(gap);
          slot_nxt      = slot_inc;
          count_nxt     = count_inc;
          if (run_r && (count_inc == STEP_FIRST || count_inc >= STEP_WRAP)) begin
            count_nxt = STEP_FIRST;
            tick      = 1'b1;
          end
        end
        FUNC_START: begin
          count_nxt     = '0;
          run_nxt       = 1'b1;
          last_time_nxt = in_ch.timestamp;
        end
        FUNC_STOP: begin
          run_nxt = 1'b0;
        end
        default: ;
      endcase
    end
  end

  assign push                 = accept;
  assign push_ctl.is_pulse    = pulse;
  assign push_ctl.step_tick   = tick;
  assign push_ctl.clock_count = count_nxt;
  assign push_ctl.is_running  = run_nxt;
  assign push_sum             = sum_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_time_r <= '0;
      sum_r       <= '0;
      slot_r      <= '0;
      count_r     <= '0;
      run_r       <= 1'b0;
      valid_r     <= '0;
    end else begin
      last_time_r <= last_time_nxt;
      sum_r       <= sum_nxt;
      slot_r      <= slot_nxt;
      count_r     <= count_nxt;
      run_r       <= run_nxt;
      if (pulse) begin
        valid_r[slot_r] <= 1'b1;
      end
    end
  end

  // write this slot, prefetch the next one (never the same address)
  always_ff @(posedge clk) begin
    if (pulse) begin
      gap_mem[slot_r] <= gap;
      rd_r            <= gap_mem[slot_inc];
    end
  end

endmodule

FILE: rtl/core/mctt_queue.sv
// Small FIFO between front and back ends.
// Depends on mctt_pkg for depth and status type.
module mctt_queue #(
  parameter int unsigned DATA_W = 47
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  input  logic              pop,
  output logic [DATA_W-1:0] pop_data,
  output mctt_pkg::q_stat_t q_stat
);
  import mctt_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

  logic [DATA_W-1:0] entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  assign q_stat.full  = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign pop_data     = entry_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: rtl/core/mctt_back.sv
// Back end: bit-serial tempo divider and the output register.
// Depends on mctt_pkg, mctt_out_if and the assertion macro header.
`include "midi_clock_tempo_tracker_defines.svh"

module mctt_back #(
  parameter int unsigned WINDOW_DEPTH = 8,
  parameter int unsigned SUM_W        = 35
) (
  input  logic               clk,
  input  logic               rst_n,
  input  mctt_pkg::q_stat_t  q_stat,
  input  mctt_pkg::job_ctl_t pop_ctl,
  input  logic [SUM_W-1:0]   pop_sum,
  output logic               pop,
  mctt_out_if.source         out_ch
);
  import mctt_pkg::*;

  // tempo = floor(NUM / sum), held to TEMPO_MIN..TEMPO_MAX; 60000*4*W/24 is an exact integer
  localparam int unsigned NUM = MS_PER_MINUTE * PULSE_SCALE * WINDOW_DEPTH / PULSES_PER_QUARTER;
  localparam int unsigned NUM_W = $clog2(NUM + 1);
  localparam int unsigned CNT_W = $clog2(NUM_W);
  localparam logic [NUM_W-1:0] NUM_VEC = NUM_W'(NUM);
  localparam logic [SUM_W-1:0] NUM_SUM = SUM_W'(NUM);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_DONE = 3'b100
  } back_state_t;

  back_state_t        state_r, state_nxt;
  job_ctl_t           ctl_r, ctl_nxt;
  logic [NUM_W-1:0]   div_r, div_nxt;
  logic [NUM_W-1:0]   rem_r, rem_nxt;
  logic [NUM_W-1:0]   quo_r, quo_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [TEMPO_W-1:0] tempo_r, tempo_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [TEMPO_W-1:0] out_tempo_r;
  logic               out_tvalid_r;
  logic               out_tick_r;
  logic [COUNT_W-1:0] out_count_r;
  logic               out_run_r;

  logic               out_free;
  logic               load_out;
  logic [NUM_W:0]     rem_sh;
  logic               q_bit;
  logic [31:0]        quo_ext;

  assign out_free = !out_valid_r || out_ch.ready;
  assign pop      = (state_r == ST_IDLE) && !q_stat.empty;
  assign load_out = (state_r == ST_DONE) && out_free;

  // one restoring step: bring down the next dividend bit, subtract if it fits
  assign rem_sh  = {rem_r, NUM_VEC[cnt_r]};
  assign q_bit   = (rem_sh >= {1'b0, div_r});
  assign quo_ext = 32'({quo_r[NUM_W-2:0], q_bit});

  always_comb begin
    state_nxt = state_r;
    ctl_nxt   = ctl_r;
    div_nxt   = div_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    cnt_nxt   = cnt_r;
    tempo_nxt = tempo_r;
    unique case (state_r)
      ST_IDLE: begin
        if (pop) begin
          ctl_nxt   = pop_ctl;
          tempo_nxt = '0;
          state_nxt = ST_DONE;
          if (pop_ctl.is_pulse) begin
            if (pop_sum == '0) begin
              tempo_nxt = TEMPO_MAX;
            end else if (pop_sum > NUM_SUM) begin
              // quotient would be zero
              tempo_nxt = TEMPO_MIN;
            end else begin
              div_nxt   = pop_sum[NUM_W-1:0];
              rem_nxt   = '0;
              quo_nxt   = '0;
              cnt_nxt   = CNT_W'(NUM_W - 1);
              state_nxt = ST_DIV;
            end
          end
        end
      end
      ST_DIV: begin
        rem_nxt = q_bit ? NUM_W'(rem_sh - {1'b0, div_r}) : rem_sh[NUM_W-1:0];
        quo_nxt = quo_ext[NUM_W-1:0];
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          tempo_nxt = (quo_ext > 32'(TEMPO_MAX)) ? TEMPO_MAX : quo_ext[TEMPO_W-1:0];
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ctl_r   <= ctl_nxt;
    div_r   <= div_nxt;
    rem_r   <= rem_nxt;
    quo_r   <= quo_nxt;
    cnt_r   <= cnt_nxt;
    tempo_r <= tempo_nxt;
    if (load_out) begin
      out_tempo_r  <= tempo_r;
      out_tvalid_r <= ctl_r.is_pulse;
      out_tick_r   <= ctl_r.step_tick;
      out_count_r  <= ctl_r.clock_count;
      out_run_r    <= ctl_r.is_running;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.tempo_bpm   = out_tempo_r;
  assign out_ch.tempo_valid = out_tvalid_r;
  assign out_ch.step_tick   = out_tick_r;
  assign out_ch.clock_count = out_count_r;
  assign out_ch.is_running  = out_run_r;

  `MCTT_ASSERT_IMPL(a_div_nonzero, state_r == ST_DIV, div_r != '0)
  `MCTT_ASSERT_IMPL(a_idle_tempo_zero, out_valid_r && !out_tvalid_r, out_tempo_r == '0)
  `MCTT_ASSERT_IMPL(a_pulse_tempo_set, out_valid_r && out_tvalid_r, out_tempo_r != '0)
  `MCTT_ASSERT_NEXT(a_pop_leaves_idle, pop, state_r != ST_IDLE)

endmodule
